>>> rtl/core/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// Shared constants and controller/datapath interface types for the
// segmented prime sieve counter.
// ----------------------------------------------------------------------------
package sps_pkg;

    // segment span and bitmap geometry
    localparam int MAX_SPAN  = 262144;
    localparam int MAP_DEPTH = MAX_SPAN / 2;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);
    localparam int CNT_W     = $clog2(MAP_DEPTH + 1);

    // request and result fields
    localparam int SEG_W   = 32;
    localparam int COUNT_W = 18;

    // odd divisors reach 65537 before d*d passes any 32-bit bound
    localparam int D_W   = 17;
    localparam int SQ_W  = 2 * D_W;
    localparam int IDX_W = ((CNT_W > D_W) ? CNT_W : D_W) + 1;

    // remainder unit retires two dividend bits per cycle
    localparam int REM_STEPS = SEG_W / 2;
    localparam int REM_CW    = $clog2(REM_STEPS);

    // stream widths
    localparam int IN_TDATA_W  = 2 * SEG_W;
    localparam int OUT_TDATA_W = ((COUNT_W + 1 + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - COUNT_W - 1;

    typedef struct packed {
        logic load;       // capture a new request
        logic chk_load;   // register candidate count and error flag
        logic k_clr;
        logic k_inc;
        logic fill_wr;    // write fill value at bitmap index k
        logic d_init;
        logic d_next;
        logic div_start;
        logic idx_load;   // first struck index for the current divisor
        logic mark_wr;    // strike at idx and step by d
        logic cnt_rd;     // read bitmap index k for the count
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic span_err;
        logic cands_zero;
        logic k_last;
        logic dsq_le_hi;
        logic lo_le_dsq;
        logic div_done;
        logic idx_in_range;
    } t_dp_sts;

endpackage

>>> rtl/core/sps_ram.sv
// ----------------------------------------------------------------------------
// sps_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module sps_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/sps_rem.sv
// ----------------------------------------------------------------------------
// sps_rem
// Iterative remainder unit: segment start modulo the current divisor,
// restoring division two bits per cycle.
// ----------------------------------------------------------------------------
module sps_rem import sps_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SEG_W-1:0] i_dividend,
    input  logic [D_W-1:0]   i_divisor,
    output logic             o_done,
    output logic [D_W-1:0]   o_rem
);

    logic              r_busy;
    logic              r_done;
    logic [REM_CW-1:0] r_cnt;
    logic [SEG_W-1:0]  r_sh;
    logic [D_W-1:0]    r_rem;
    logic [D_W-1:0]    n_rem_a;
    logic [D_W-1:0]    n_rem_b;

    function automatic logic [D_W-1:0] rem_bit(
        input logic [D_W-1:0] rem,
        input logic           b,
        input logic [D_W-1:0] d
    );
        logic [D_W:0] t;
        t = {rem, b};
        if (t >= {1'b0, d}) begin
            t = t - {1'b0, d};
        end
        return t[D_W-1:0];
    endfunction

    always_comb begin
        n_rem_a = rem_bit(r_rem, r_sh[SEG_W-1], i_divisor);
        n_rem_b = rem_bit(n_rem_a, r_sh[SEG_W-2], i_divisor);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + REM_CW'(1);
            if (r_cnt == REM_CW'(REM_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh  <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_sh  <= r_sh << 2;
            r_rem <= n_rem_b;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> rtl/core/sps_dp.sv
// ----------------------------------------------------------------------------
// sps_dp
// Sieve datapath: segment bounds, candidate count, divisor and its square,
// strike index, bitmap port drive, population count and result registers.
// ----------------------------------------------------------------------------
module sps_dp import sps_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic [SEG_W-1:0]   i_seg_start,
    input  logic [SEG_W-1:0]   i_seg_end,
    output logic               o_ram_we,
    output logic [MAP_AW-1:0]  o_ram_waddr,
    output logic               o_ram_wdata,
    output logic [MAP_AW-1:0]  o_ram_raddr,
    input  logic               i_ram_rdata,
    output logic [COUNT_W-1:0] o_prime_count,
    output logic               o_span_error
);

    logic [SEG_W-1:0]   r_lo;
    logic [SEG_W-1:0]   r_hi;
    logic [CNT_W-1:0]   r_cands;
    logic               r_err;
    logic [MAP_AW-1:0]  r_k;
    logic [D_W-1:0]     r_d;
    logic [SQ_W-1:0]    r_dsq;
    logic [IDX_W-1:0]   r_idx;
    logic               r_rd_vld;
    logic [CNT_W-1:0]   r_acc;
    logic [COUNT_W-1:0] r_count;
    logic               r_span_err;

    logic [SEG_W:0]     diff;
    logic [SEG_W:0]     cands_full;
    logic               span_err;
    logic [D_W-1:0]     rem;
    logic               div_done;
    logic [D_W-1:0]     off;
    logic [D_W:0]       delta_div;
    logic [SQ_W-1:0]    delta_sq;
    logic [IDX_W-1:0]   n_idx0;
    logic               lo_le_dsq;
    logic               fill_bit;

    sps_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_lo),
        .i_divisor  (r_d),
        .o_done     (div_done),
        .o_rem      (rem)
    );

    always_comb begin
        diff       = {1'b0, r_hi} - {1'b0, r_lo};
        cands_full = ({1'b0, diff[SEG_W-1:0]} + (SEG_W + 1)'(1)) >> 1;
        span_err   = diff[SEG_W] || (cands_full > (SEG_W + 1)'(MAP_DEPTH));
        lo_le_dsq  = {{(SQ_W - SEG_W){1'b0}}, r_lo} <= r_dsq;

        // distance from lo to the first odd multiple at or above lo
        off       = (rem == '0) ? '0 : (r_d - rem);
        delta_div = {1'b0, off} + (off[0] ? '0 : {1'b0, r_d});
        delta_sq  = r_dsq - {{(SQ_W - SEG_W){1'b0}}, r_lo};
        if (lo_le_dsq) begin
            n_idx0 = IDX_W'((delta_sq - SQ_W'(1)) >> 1);
        end else begin
            n_idx0 = IDX_W'((delta_div - (D_W + 1)'(1)) >> 1);
        end

        // the number one is not prime
        fill_bit = !((r_k == '0) && (r_lo == '0));
    end

    always_comb begin
        o_sts.span_err     = span_err;
        o_sts.cands_zero   = (cands_full == '0);
        o_sts.k_last       = (CNT_W'(r_k) + CNT_W'(1)) == r_cands;
        o_sts.dsq_le_hi    = r_dsq <= {{(SQ_W - SEG_W){1'b0}}, r_hi};
        o_sts.lo_le_dsq    = lo_le_dsq;
        o_sts.div_done     = div_done;
        o_sts.idx_in_range = r_idx < IDX_W'(r_cands);
    end

    always_comb begin
        o_ram_we    = i_cmd.fill_wr || i_cmd.mark_wr;
        o_ram_waddr = i_cmd.mark_wr ? r_idx[MAP_AW-1:0] : r_k;
        o_ram_wdata = i_cmd.mark_wr ? 1'b0 : fill_bit;
        o_ram_raddr = r_k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.cnt_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lo <= {i_seg_start[SEG_W-1:1], 1'b0};
            r_hi <= i_seg_end;
        end
        if (i_cmd.chk_load) begin
            r_cands <= CNT_W'(cands_full);
            r_err   <= span_err;
        end
        if (i_cmd.k_clr) begin
            r_k <= '0;
        end else if (i_cmd.k_inc) begin
            r_k <= r_k + MAP_AW'(1);
        end
        if (i_cmd.d_init) begin
            r_d   <= D_W'(3);
            r_dsq <= SQ_W'(9);
        end else if (i_cmd.d_next) begin
            // (d+2)^2 = d^2 + 4d + 4
            r_d   <= r_d + D_W'(2);
            r_dsq <= r_dsq + (SQ_W'(r_d) << 2) + SQ_W'(4);
        end
        if (i_cmd.idx_load) begin
            r_idx <= n_idx0;
        end else if (i_cmd.mark_wr) begin
            r_idx <= r_idx + IDX_W'(r_d);
        end
        if (i_cmd.chk_load) begin
            r_acc <= '0;
        end else if (r_rd_vld && i_ram_rdata) begin
            r_acc <= r_acc + CNT_W'(1);
        end
        if (i_cmd.out_load) begin
            r_count    <= COUNT_W'(r_acc);
            r_span_err <= r_err;
        end
    end

    assign o_prime_count = r_count;
    assign o_span_error  = r_span_err;

endmodule

>>> rtl/core/sps_ctrl.sv
// ----------------------------------------------------------------------------
// sps_ctrl
// Sieve sequencer: check, bitmap fill, per-divisor strike loop, count pass
// and result hand-off.
// ----------------------------------------------------------------------------
module sps_ctrl import sps_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_FILL  = 4'd2;
    localparam logic [3:0] S_DTEST = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_IDX   = 4'd5;
    localparam logic [3:0] S_MARK  = 4'd6;
    localparam logic [3:0] S_COUNT = 4'd7;
    localparam logic [3:0] S_DRAIN = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.chk_load = 1'b1;
                o_cmd.k_clr    = 1'b1;
                if (i_sts.span_err || i_sts.cands_zero) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                o_cmd.fill_wr = 1'b1;
                o_cmd.k_inc   = 1'b1;
                if (i_sts.k_last) begin
                    o_cmd.d_init = 1'b1;
                    n_state      = S_DTEST;
                end
            end
            S_DTEST: begin
                if (i_sts.dsq_le_hi) begin
                    if (i_sts.lo_le_dsq) begin
                        n_state = S_IDX;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end
                end else begin
                    o_cmd.k_clr = 1'b1;
                    n_state     = S_COUNT;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_IDX;
                end
            end
            S_IDX: begin
                o_cmd.idx_load = 1'b1;
                n_state        = S_MARK;
            end
            S_MARK: begin
                if (i_sts.idx_in_range) begin
                    o_cmd.mark_wr = 1'b1;
                end else begin
                    o_cmd.d_next = 1'b1;
                    n_state      = S_DTEST;
                end
            end
            S_COUNT: begin
                o_cmd.cnt_rd = 1'b1;
                o_cmd.k_inc  = 1'b1;
                if (i_sts.k_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last read data lands in the accumulator
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/core/segmented_prime_sieve_counter_top.sv
// ----------------------------------------------------------------------------
// segmented_prime_sieve_counter_top
// Counts the odd primes in one segment (start, end] per request.
//
// Input stream carries one request per transaction: seg_start (even, lower
// bound, exclusive) and seg_end (inclusive). Output stream returns one
// transaction per request with prime_count and span_error. span_error is set
// with a zero count when end is below start rounded down to even, or the
// segment holds more odd candidates than the bitmap.
// One request is worked at a time. The bitmap fill and count pass take one
// bitmap entry a cycle; for each odd divisor d with d*d <= end the strike
// loop writes one multiple per cycle (single bitmap write port), after the
// 2-bit-per-cycle remainder unit has run when start lies above d*d.
// Rejected or empty requests go straight from the check to the result.
// The result sits in an output register, so a new request is accepted while
// the previous result waits for the receiver; a stalled receiver only
// holds the sequencer when a second result is ready.
// Synchronous reset returns the sequencer to idle and drops the output
// valid; the bitmap is refilled at the start of every segment.
// ----------------------------------------------------------------------------
module segmented_prime_sieve_counter_top import sps_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // seg_start[31:0], seg_end[63:32]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // prime_count[17:0], span_error[18], zero pad
);

    t_dp_cmd            cmd;
    t_dp_sts            sts;
    logic               ram_we;
    logic [MAP_AW-1:0]  ram_waddr;
    logic               ram_wdata;
    logic [MAP_AW-1:0]  ram_raddr;
    logic               ram_rdata;
    logic [COUNT_W-1:0] prime_count;
    logic               span_error;

    sps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    sps_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_seg_start   (s_axis_tdata[SEG_W-1:0]),
        .i_seg_end     (s_axis_tdata[2*SEG_W-1:SEG_W]),
        .o_ram_we      (ram_we),
        .o_ram_waddr   (ram_waddr),
        .o_ram_wdata   (ram_wdata),
        .o_ram_raddr   (ram_raddr),
        .i_ram_rdata   (ram_rdata),
        .o_prime_count (prime_count),
        .o_span_error  (span_error)
    );

    sps_ram #(
        .WIDTH (1),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, span_error, prime_count};

endmodule

>>> rtl/core/sps_checker.sv
// ----------------------------------------------------------------------------
// sps_checker
// Port-level checks on the sieve counter, bound to the top level.
// ----------------------------------------------------------------------------
module sps_checker import sps_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // reset drops any pending result
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // one request in flight: busy right after a transaction
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while busy");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // error results carry a zero count
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[COUNT_W] == 1'b0)
            || (m_axis_tdata[COUNT_W-1:0] == '0))
        else $error("span error with nonzero count");

    // count never exceeds the bitmap
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[COUNT_W-1:0] <= COUNT_W'(MAP_DEPTH))
        else $error("count above bitmap depth");

endmodule

bind segmented_prime_sieve_counter_top sps_checker u_sps_checker (.*);

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for segmented_prime_sieve_counter_top. A queue of
// segment requests (directed corners, a burst of short segments under a long
// output hold-off, then random segments) feeds a stream driver. Each accepted
// request is sieved in the bench, and the expected count and error flag are
// compared field by field with every result transaction in order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sps_pkg::*;

    localparam int HOLD_CYCLES = 3000;
    localparam int CALM_LO     = 60;
    localparam int CALM_HI     = 80;
    localparam int BURST_SEGS  = 6;
    localparam int RANDOM_SEGS = 80;

    typedef struct packed {
        logic [SEG_W-1:0] seg_end;
        logic [SEG_W-1:0] seg_start;
    } t_sieve_req;

    typedef struct packed {
        logic               span_error;
        logic [COUNT_W-1:0] prime_count;
    } t_sieve_res;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // seg_start[31:0], seg_end[63:32]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // prime_count[17:0], span_error[18], pad

    t_sieve_req pending_segs[$];
    t_sieve_res expected_counts[$];
    bit         odd_map [MAP_DEPTH];

    int      n_segs = 0;
    int      n_directed = 0;
    int      n_issued = 0;
    int      n_checked = 0;
    int      n_fail = 0;
    int      hold_left = 0;
    bit      hold_armed = 1'b1;
    longint  cycle_budget = 0;
    longint  cycle_limit = 64'd1 << 40;
    longint  cycle_count = 0;

    wire tx_calm = (n_issued >= CALM_LO) && (n_issued < CALM_HI);
    wire rx_calm = (n_checked >= CALM_LO) && (n_checked < CALM_HI);

    segmented_prime_sieve_counter_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // sieve of the odd numbers lo+1, lo+3, ... hi
    function automatic t_sieve_res count_segment_primes(t_sieve_req req);
        longint unsigned lo, hi, cands, d, m, idx, total;
        t_sieve_res res;
        lo = 64'(req.seg_start);
        lo[0] = 1'b0;
        hi = 64'(req.seg_end);
        res.prime_count = '0;
        res.span_error = 1'b1;
        if (hi < lo) return res;
        cands = (hi - lo + 1) / 2;
        if (cands > MAP_DEPTH) return res;
        for (idx = 0; idx < cands; idx++) odd_map[idx[MAP_AW-1:0]] = 1'b1;
        if (lo == 0 && cands > 0) odd_map[0] = 1'b0;
        for (d = 3; d * d <= hi; d += 2) begin
            m = (lo + d - 1) / d * d;
            if (m < d * d) m = d * d;
            if (!m[0]) m += d;
            while (m <= hi) begin
                idx = (m - lo - 1) / 2;
                odd_map[idx[MAP_AW-1:0]] = 1'b0;
                m += 2 * d;
            end
        end
        total = 0;
        for (idx = 0; idx < cands; idx++) total += odd_map[idx[MAP_AW-1:0]];
        res.prime_count = total[COUNT_W-1:0];
        res.span_error = 1'b0;
        return res;
    endfunction

    task automatic queue_segment(input logic [SEG_W-1:0] seg_start,
                                 input logic [SEG_W-1:0] seg_end);
        t_sieve_req req;
        longint unsigned lo, cands;
        req.seg_start = seg_start;
        req.seg_end = seg_end;
        pending_segs.push_back(req);
        n_segs++;
        lo = 64'(seg_start);
        lo[0] = 1'b0;
        // fill, strikes, per-divisor remainder and count pass, plus stalls
        cycle_budget += 100;
        if (seg_end > lo && (seg_end - lo + 1) / 2 <= MAP_DEPTH) begin
            cands = (seg_end - lo + 1) / 2;
            cycle_budget += 40 + 8 * cands + 21 * ($rtoi($sqrt(real'(seg_end))) / 2 + 1);
        end
    endtask

    task automatic queue_random_segment();
        logic [SEG_W-1:0] lo, hi;
        int unsigned pick, cands;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            // end below start
            hi = $urandom_range(0, 32'hFFFFFFFD);
            lo = $urandom_range(hi + 2, 32'hFFFFFFFF);
            queue_segment(lo, hi);
        end else if (pick < 14) begin
            // more odd candidates than the bitmap holds
            lo = $urandom_range(0, 32'hFFBFFFFF) & ~32'd1;
            hi = lo + 32'd262145 + $urandom_range(0, 32'h0003FFFF);
            queue_segment(lo | $urandom_range(0, 1), hi);
        end else if (pick < 24) begin
            // end equals the bound
            lo = $urandom;
            queue_segment(lo, lo & ~32'd1);
        end else begin
            lo = ($urandom_range(0, 9) == 0) ? '0 : ($urandom_range(0, 1 << 18) & ~32'd1);
            pick = $urandom_range(0, 99);
            if (pick < 70) cands = $urandom_range(1, 64);
            else if (pick < 95) cands = $urandom_range(1, 1024);
            else cands = $urandom_range(1, 8192);
            hi = lo + 2 * cands - 1 + $urandom_range(0, 1);
            queue_segment(lo | SEG_W'($urandom_range(0, 4) == 0), hi);
        end
    endtask

    // driver: keeps the request offered until accepted
    always @(posedge i_clk) begin : drv
        t_sieve_req req;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                req = s_axis_tdata;
                expected_counts.push_back(count_segment_primes(req));
                n_issued <= n_issued + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_segs.size() != 0 && (tx_calm || $urandom_range(0, 99) >= 36)) begin
                    s_axis_tdata  <= pending_segs.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // one long output hold-off while the short burst is being offered
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_armed && n_directed != 0 && n_checked >= n_directed) begin
            hold_left  <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end
    end

    // monitor: checks each result transaction against the oldest expectation
    always @(posedge i_clk) begin : mon
        t_sieve_res got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= (hold_left == 0) && (rx_calm || $urandom_range(0, 99) >= 36);
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[COUNT_W:0];
                if (expected_counts.size() == 0) begin
                    $display("%0t: result with none pending, count %0d error %0b",
                             $time, got.prime_count, got.span_error);
                    n_fail++;
                end else begin
                    want = expected_counts.pop_front();
                    if (got.prime_count !== want.prime_count) begin
                        $display("%0t: prime_count expected %0d actual %0d",
                                 $time, want.prime_count, got.prime_count);
                        n_fail++;
                    end
                    if (got.span_error !== want.span_error) begin
                        $display("%0t: span_error expected %0b actual %0b",
                                 $time, want.span_error, got.span_error);
                        n_fail++;
                    end
                end
                n_checked <= n_checked + 1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > cycle_limit) begin
            $display("segmented_prime_sieve_counter_top verification failed");
            $finish;
        end
    end

    initial begin
        queue_segment(32'd0, 32'd0);
        queue_segment(32'd0, 32'd1);              // one is not prime
        queue_segment(32'd0, 32'd2);
        queue_segment(32'd0, 32'd3);
        queue_segment(32'd2, 32'd3);
        queue_segment(32'd0, 32'd9);              // square at the very end
        queue_segment(32'd8, 32'd9);
        queue_segment(32'd0, 32'd25);
        queue_segment(32'd120, 32'd121);
        queue_segment(32'd1, 32'd100);            // odd start
        queue_segment(32'd100, 32'd100);          // empty
        queue_segment(32'd101, 32'd100);
        queue_segment(32'd100, 32'd99);           // end below start
        queue_segment(32'hFFFFFFFE, 32'd0);
        queue_segment(32'h7FFF0000, 32'h7FFEFFFF);
        queue_segment(32'hFFFFFFFF, 32'hFFFFFFFE);
        queue_segment(32'hFFFFFFF0, 32'hFFFFFFFF); // every divisor up to 65535
        queue_segment(32'd0, 32'd262143);         // full bitmap
        queue_segment(32'd0, 32'd262145);         // one candidate too many
        queue_segment(32'h80000000, 32'h80040001);
        queue_segment(32'd1000000, 32'd1000200);
        queue_segment(32'd0, 32'd65536);
        n_directed = n_segs;
        // short segments that pile up behind the held output
        repeat (BURST_SEGS) begin
            queue_segment($urandom_range(0, 1000) & ~32'd1, 0);
            pending_segs[$].seg_end = pending_segs[$].seg_start + 2 * $urandom_range(1, 16);
        end
        repeat (RANDOM_SEGS) queue_random_segment();
        cycle_limit = 3 * cycle_budget + 3 * HOLD_CYCLES + 20000;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(n_issued == n_segs && expected_counts.size() == 0)) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("segmented_prime_sieve_counter_top verification clean");
        end else begin
            $display("segmented_prime_sieve_counter_top verification failed");
        end
        $finish;
    end

endmodule
